### rtl/triggered_edge_timestamp_capture_core_defines.svh
// Assertion macros for the edge timestamp capture core and its checker.
// Included by the checker only; no other dependencies.
`ifndef TRIGGERED_EDGE_TIMESTAMP_CAPTURE_CORE_DEFINES_SVH
`define TRIGGERED_EDGE_TIMESTAMP_CAPTURE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define TETC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tetc assertion failed");

// Next-cycle implication, disabled while in reset
`define TETC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tetc assertion failed");

`endif

### rtl/tetc_pkg.sv
// Shared types, codes and helpers for the edge timestamp capture core.
// No dependencies; compiled first.
package tetc_pkg;

	localparam int unsigned MAX_STAMPS_DEFAULT = 256;
	localparam int unsigned CFG_IDX_W          = 1;
	localparam int unsigned CFG_DATA_W         = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_WINDOW  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TIMEOUT = 1'd1;

	localparam logic [30:0] CAPTURE_WINDOW_RST  = 31'd1920000;
	localparam logic [31:0] TRIGGER_TIMEOUT_RST = 32'd432000000;

	// Operation codes
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ARM  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// Phase codes
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_WAIT    = 3'd1;
	localparam logic [2:0] PH_CAPTURE = 3'd2;
	localparam logic [2:0] PH_DONE    = 3'd3;
	localparam logic [2:0] PH_TIMEOUT = 3'd4;

	typedef struct packed {
		logic [1:0] operation;
		logic       level;
		logic [7:0] read_index;
	} item_t;

	typedef struct packed {
		logic        stamp_level;
		logic [30:0] stamp_time;
		logic        read_valid;
		logic [8:0]  stamp_count;
		logic [2:0]  phase;
	} result_t;

	// Address bits for a memory of the given depth
	function automatic int unsigned addr_bits(input int unsigned depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

### rtl/tetc_stream_if.sv
// Valid/ready channel carrying one payload per transfer.
// Payload type is a parameter; no other dependencies.
interface tetc_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/triggered_edge_timestamp_capture_core.sv
// Edge timestamp capture core: results pass through the stage 1 and output
// registers. Throughput is one item per cycle while the result side is not
// stalled; the stamp RAM is written by tick items and read by read items,
// never both for one item, so no forwarding is needed.
// Asynchronous active-low reset returns to idle with the tick count at zero
// and the registers at their defaults; the stamp RAM is not cleared.
module triggered_edge_timestamp_capture_core import tetc_pkg::*; #(
	parameter int unsigned MAX_STAMPS = MAX_STAMPS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tetc_stream_if.sink           item,
	tetc_stream_if.source         result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned AW = addr_bits(MAX_STAMPS);
	localparam int unsigned CW = $clog2(MAX_STAMPS + 1);
	localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_STAMPS);

	// Configuration and control state
	logic [30:0]   window_q;
	logic [31:0]   timeout_q;
	logic [31:0]   tick_q;
	logic [31:0]   phase_start_q;
	logic [2:0]    phase_q;
	logic          prev_level_q;
	logic [CW-1:0] count_q;

	// Pipeline
	logic          valid_s1;
	logic          hit_s1;
	logic [8:0]    count_s1;
	logic [2:0]    phase_s1;
	logic          out_valid_q;
	result_t       out_q;
	logic [31:0]   rdata;

	item_t         it;
	logic          acc;
	logic          s1_move;
	logic [31:0]   elapsed;
	logic          line_edge;
	logic          read_hit;
	logic          stamp_we;
	logic [2:0]    phase_d;
	logic [31:0]   phase_start_d;
	logic [CW-1:0] count_d;

	assign it      = item.payload;
	assign s1_move = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || s1_move;
	assign acc     = item.valid && item.ready;

	assign elapsed   = tick_q - phase_start_q;
	assign line_edge = (it.level != prev_level_q);
	assign read_hit  = (it.operation == OP_READ) && (32'(it.read_index) < 32'(count_q));

	// Phase sequencing and stamp write decision
	always_comb begin
		phase_d       = phase_q;
		phase_start_d = phase_start_q;
		count_d       = count_q;
		stamp_we      = 1'b0;
		if (acc) begin
			case (it.operation)
				OP_TICK: begin
					if (phase_q == PH_WAIT) begin
						if (line_edge) begin
							phase_d       = PH_CAPTURE;
							phase_start_d = tick_q;
						end else if (elapsed >= timeout_q) begin
							phase_d = PH_TIMEOUT;
						end
					end else if (phase_q == PH_CAPTURE) begin
						if (elapsed > {1'b0, window_q}) begin
							phase_d = PH_DONE;
						end else if (line_edge && (count_q < COUNT_FULL)) begin
							stamp_we = 1'b1;
							count_d  = count_q + 1'b1;
						end
					end
				end
				OP_ARM: begin
					phase_d       = PH_WAIT;
					phase_start_d = tick_q;
					count_d       = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q      <= CAPTURE_WINDOW_RST;
			timeout_q     <= TRIGGER_TIMEOUT_RST;
			tick_q        <= '0;
			phase_start_q <= '0;
			phase_q       <= PH_IDLE;
			prev_level_q  <= 1'b0;
			count_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CAPTURE_WINDOW:  window_q  <= cfg_data[30:0];
					REG_TRIGGER_TIMEOUT: timeout_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (acc) begin
				tick_q <= tick_q + 32'd1;
				if (it.operation == OP_TICK) begin
					prev_level_q <= it.level;
				end
			end
			phase_q       <= phase_d;
			phase_start_q <= phase_start_d;
			count_q       <= count_d;
		end
	end

	// Stamp store: level before the edge in bit 31, tick time below
	tetc_ram #(
		.WIDTH(32),
		.DEPTH(MAX_STAMPS)
	) u_stamp_ram (
		.clk  (clk),
		.we   (stamp_we),
		.waddr(count_q[AW-1:0]),
		.wdata({prev_level_q, tick_q[30:0]}),
		.re   (acc && read_hit),
		.raddr(AW'(it.read_index)),
		.rdata(rdata)
	);

	// Stage 1 valid and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage 1 payload: status after the item, RAM data lands alongside
	always_ff @(posedge clk) begin
		if (acc) begin
			hit_s1   <= read_hit;
			count_s1 <= 9'(count_d);
			phase_s1 <= phase_d;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q.stamp_level <= hit_s1 ? rdata[31] : 1'b0;
			out_q.stamp_time  <= hit_s1 ? rdata[30:0] : 31'd0;
			out_q.read_valid  <= hit_s1;
			out_q.stamp_count <= count_s1;
			out_q.phase       <= phase_s1;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

endmodule

### rtl/tetc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on tetc_pkg for the address width helper.
module tetc_ram import tetc_pkg::*; #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = MAX_STAMPS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [addr_bits(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]              wdata,
	input  logic                          re,
	input  logic [addr_bits(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, output holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/tetc_checker.sv
// Port-level checker for the edge timestamp capture core, bound to the top.
// Depends on tetc_pkg and the assertion macro header.
`include "triggered_edge_timestamp_capture_core_defines.svh"

module tetc_checker import tetc_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result_payload
);

	logic item_xfer;
	assign item_xfer = item_valid && item_ready;

	// A stalled result holds its payload
	`TETC_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, $stable(result_payload))
	// Every input transfer yields a pending result once it has passed the stage 1 register
	`TETC_ASSERT_NEXT(a_result_follows, clk, arst_n, item_xfer, ##1 result_valid)
	// Input side only stalls when a result is waiting
	`TETC_ASSERT_NOW(a_stall_cause, clk, arst_n, !item_ready, result_valid)
	// Before the first arm nothing is ever stamped
	`TETC_ASSERT_NOW(a_idle_empty, clk, arst_n, result_valid && (result_payload.phase == PH_IDLE), (result_payload.stamp_count == 9'd0) && !result_payload.read_valid)

endmodule

bind triggered_edge_timestamp_capture_core tetc_checker u_tetc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_payload(result.payload)
);
